### rtl/pbt_pkg.sv
package pbt_pkg;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 48;
  localparam int MS_W   = 39;
  localparam int CONF_W = 8;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 80;  // addr + time, already whole bytes
  localparam int OUT_DATA_W = 48;  // interval_ms + confidence, padded to bytes
  localparam int OUT_USER_W = 3;   // status + alert

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_JITTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] JITTER_RST = TIME_W'(100000);
  localparam logic [CONF_W-1:0] LIMIT_RST  = CONF_W'(5);
  localparam logic [CONF_W-1:0] CONF_MAX   = '1;

  localparam logic [STAT_W-1:0] ST_KNOWN = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_NEW   = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

  // divide by 1000 as ((x >> 3) * ceil(2^52 / 125)) >> 52, exact for 45-bit x >> 3;
  // the multiply is split in 23-bit halves, one partial product per cycle
  localparam int DIVISOR     = 1000;
  localparam int DIV_PRE_SH  = 3;
  localparam int DIV_POST_SH = 52;
  localparam int DIV_HALF_W  = 23;
  localparam int DIV_OP_W    = 2 * DIV_HALF_W;
  localparam int DIV_ACC_W   = 2 * DIV_OP_W;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam logic [DIV_OP_W-1:0] DIV_RECIP = 46'd36028797018964;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] last_interval;
    logic [CONF_W-1:0] conf;
  } pbt_entry_t;

  typedef struct packed {
    logic       we;
    pbt_entry_t entry;
  } pbt_wr_t;

endpackage

### rtl/pbt_cell.sv
module pbt_cell #(
  parameter int CNT_W = 8,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  logic [pbt_pkg::ADDR_W-1:0] key,
  input  logic [CNT_W-1:0]          used,
  input  pbt_pkg::pbt_wr_t          wr,
  output logic                      hit,
  output pbt_pkg::pbt_entry_t       entry
);
  import pbt_pkg::*;

  pbt_entry_t entry_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      entry_r <= wr.entry;
    end
  end

  // only slots below the fill count hold a written entry
  assign hit   = (CNT_W'(IDX) < used) && (entry_r.addr == key);
  assign entry = entry_r;

endmodule

### rtl/pbt_div1000.sv
module pbt_div1000 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pbt_pkg::TIME_W-1:0] dividend,
  output logic                       done,
  output logic [pbt_pkg::MS_W-1:0]   quotient
);
  import pbt_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_OP_W-1:0]   y_r;
  logic [DIV_ACC_W-1:0]  acc_r;
  logic [DIV_HALF_W-1:0] op_a;
  logic [DIV_HALF_W-1:0] op_b;
  logic [DIV_OP_W-1:0]   prod;
  logic [DIV_ACC_W-1:0]  prod_sh;

  // step 0: lo*lo, steps 1 and 2: cross terms, step 3: hi*hi
  always_comb begin
    op_a = cnt_r[1] ? y_r[DIV_OP_W-1 -: DIV_HALF_W] : y_r[DIV_HALF_W-1:0];
    op_b = cnt_r[0] ? DIV_RECIP[DIV_OP_W-1 -: DIV_HALF_W] : DIV_RECIP[DIV_HALF_W-1:0];
    prod = DIV_OP_W'(op_a) * DIV_OP_W'(op_b);
    case (cnt_r)
      DIV_CNT_W'(0):             prod_sh = DIV_ACC_W'(prod);
      DIV_CNT_W'(DIV_STEPS - 1): prod_sh = {prod, {DIV_OP_W{1'b0}}};
      default:                   prod_sh = {{DIV_HALF_W{1'b0}}, prod, {DIV_HALF_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        y_r    <= DIV_OP_W'(dividend[TIME_W-1:DIV_PRE_SH]);
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_r + prod_sh;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = acc_r[DIV_POST_SH +: MS_W];

endmodule

### rtl/periodic_source_beacon_tracker.sv
// A known source's result passes through match, select, interval, jitter
// check, confidence, 4 multiply steps of the divide by 1000, pickup and the
// output register; a new or ignored source goes from interval to output.
// One word at a time: the next word is taken once the result is loaded out.
// Reset (rst_n low, synchronous): table fill count cleared, registers to
// threshold 100000 us and limit 5, output channel empty.
module periodic_source_beacon_tracker #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: src_ip_addr[31:0], time_us[79:32]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pbt_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: interval_ms[38:0], confidence[46:39], zero[47]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pbt_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[1:0], alert[2]
  output logic [pbt_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbt_pkg::TIME_W-1:0]     cfg_data
);
  import pbt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_SELECT, S_CALC, S_JUDGE, S_CONF, S_DIV, S_DONE
  } state_t;

  state_t             state_r;
  logic [TIME_W-1:0]  jitter_r;
  logic [CONF_W-1:0]  limit_r;
  logic [CNT_W-1:0]   used_r;
  logic [ADDR_W-1:0]  key_r;
  logic [TIME_W-1:0]  now_r;
  logic [TABLE_ENTRIES-1:0] hit_r;
  pbt_entry_t         sel_r;
  logic               any_hit_r;
  logic [TIME_W-1:0]  cur_r;
  logic [TIME_W-1:0]  diff_r;
  logic               prev_nz_r;
  logic [STAT_W-1:0]  res_status_r;
  logic               res_alert_r;
  logic [CONF_W-1:0]  res_conf_r;
  logic [MS_W-1:0]    res_ms_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_alert_r;
  logic [CONF_W-1:0]  out_conf_r;
  logic [MS_W-1:0]    out_ms_r;

  logic [TABLE_ENTRIES-1:0] hit_vec;
  pbt_entry_t         cell_entry [TABLE_ENTRIES];
  pbt_entry_t         sel_nxt;
  pbt_entry_t         wr_entry;
  logic               do_append;
  logic               do_update;
  logic               room;
  logic               periodic;
  logic [CONF_W-1:0]  conf_inc;
  logic               div_done;
  logic [MS_W-1:0]    div_q;
  logic               out_load;

  assign room = used_r < CNT_W'(TABLE_ENTRIES);

  // row of table cells, each holding one tracked source
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pbt_wr_t cell_wr;
    assign cell_wr.we = (do_append && (used_r == CNT_W'(g))) || (do_update && hit_r[g]);
    assign cell_wr.entry = wr_entry;
    pbt_cell #(.CNT_W(CNT_W), .IDX(g)) u_cell (
      .clk   (clk),
      .key   (key_r),
      .used  (used_r),
      .wr    (cell_wr),
      .hit   (hit_vec[g]),
      .entry (cell_entry[g])
    );
  end

  // addresses are unique in the table, so at most one hit: AND-OR select
  always_comb begin
    sel_nxt = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      sel_nxt = sel_nxt | (hit_r[k] ? cell_entry[k] : '0);
    end
  end

  assign do_append = (state_r == S_CALC) && !any_hit_r && room;
  assign do_update = (state_r == S_CONF);

  // a stored interval of zero means no previous interval yet
  assign periodic = prev_nz_r && (diff_r < jitter_r);
  assign conf_inc = (sel_r.conf == CONF_MAX) ? CONF_MAX : sel_r.conf + CONF_W'(1);

  always_comb begin
    wr_entry.addr      = key_r;
    wr_entry.last_time = now_r;
    if (do_update) begin
      wr_entry.last_interval = cur_r;
      wr_entry.conf          = periodic ? conf_inc : '0;
    end else begin
      wr_entry.last_interval = '0;
      wr_entry.conf          = '0;
    end
  end

  pbt_div1000 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (do_update),
    .dividend (cur_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // output register must be free or emptying this cycle
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      jitter_r    <= JITTER_RST;
      limit_r     <= LIMIT_RST;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_JITTER: jitter_r <= cfg_data;
          CFG_LIMIT:  limit_r  <= cfg_data[CONF_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            key_r   <= in_tdata[ADDR_W-1:0];
            now_r   <= in_tdata[ADDR_W +: TIME_W];
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_r   <= hit_vec;
          state_r <= S_SELECT;
        end
        S_SELECT: begin
          sel_r     <= sel_nxt;
          any_hit_r <= |hit_r;
          state_r   <= S_CALC;
        end
        S_CALC: begin
          // interval wraps with the 48-bit timestamp
          cur_r <= now_r - sel_r.last_time;
          if (any_hit_r) begin
            state_r <= S_JUDGE;
          end else begin
            res_status_r <= room ? ST_NEW : ST_FULL;
            res_alert_r  <= 1'b0;
            res_conf_r   <= '0;
            res_ms_r     <= '0;
            if (room) begin
              used_r <= used_r + CNT_W'(1);
            end
            state_r <= S_DONE;
          end
        end
        S_JUDGE: begin
          diff_r    <= (cur_r >= sel_r.last_interval) ? cur_r - sel_r.last_interval
                                                      : sel_r.last_interval - cur_r;
          prev_nz_r <= (sel_r.last_interval != '0);
          state_r   <= S_CONF;
        end
        S_CONF: begin
          res_status_r <= ST_KNOWN;
          res_alert_r  <= periodic && (conf_inc >= limit_r);
          res_conf_r   <= periodic ? conf_inc : '0;
          state_r      <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_ms_r <= div_q;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_alert_r  <= res_alert_r;
            out_conf_r   <= res_conf_r;
            out_ms_r     <= res_ms_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_conf_r, out_ms_r};
  assign out_tuser  = {out_alert_r, out_status_r};

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pbt_pkg::*;

  localparam int TABLE_ENTRIES = 128;
  localparam int POOL_N        = 16;       // tracked beacon sources driven by the random part
  localparam int IDLE_MAX      = 17;       // longest gap / stall per word, in cycles
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int DRAIN_CYCLES  = 40;

  // register indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              alert;
    logic [MS_W-1:0]   interval_ms;
    logic [CONF_W-1:0] conf;
  } beacon_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [TIME_W-1:0]     cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_ready;

  always #5 clk = ~clk;

  periodic_source_beacon_tracker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // src_ip_addr[31:0], time_us[79:32]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // interval_ms[38:0], confidence[46:39], pad[47]
    .out_tuser (out_tuser),   // status[1:0], alert[2]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the source table and registers. Only entries below
  // trk_used are ever looked at, so the unwritten part never matters.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] trk_addr      [TABLE_ENTRIES];
  logic [TIME_W-1:0] trk_last_time [TABLE_ENTRIES];
  logic [TIME_W-1:0] trk_last_iv   [TABLE_ENTRIES];
  logic [CONF_W-1:0] trk_conf      [TABLE_ENTRIES];
  int                trk_used    = 0;
  logic [TIME_W-1:0] jitter_us   = JITTER_RST;
  logic [CONF_W-1:0] alert_limit = LIMIT_RST;

  beacon_result_t expected_q[$];   // one result per accepted packet, in order
  int             err_count   = 0;
  int             cycle_count = 0;
  bit             tx_idle_en  = 1'b1;
  bit             rx_idle_en  = 1'b1;

  // random-part source pool: address, time of the last packet sent, period
  logic [ADDR_W-1:0] src_addr   [POOL_N];
  logic [TIME_W-1:0] src_time   [POOL_N];
  logic [TIME_W-1:0] src_period [POOL_N];

  // Table lookup and confidence update for one packet; returns the result word.
  function automatic beacon_result_t track_packet(input logic [ADDR_W-1:0] addr,
                                                  input logic [TIME_W-1:0] now);
    beacon_result_t    r;
    logic [TIME_W-1:0] cur;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] diff;
    logic [CONF_W-1:0] conf;
    r = '0;
    for (int k = 0; k < trk_used; k++) begin
      if (trk_addr[k] == addr) begin
        cur  = now - trk_last_time[k];   // wraps mod 2^48 by width
        prev = trk_last_iv[k];
        diff = (cur >= prev) ? cur - prev : prev - cur;
        conf = trk_conf[k];
        // a stored interval of zero means there is nothing to compare with
        if (prev != '0 && diff < jitter_us) begin
          if (conf != CONF_MAX) conf++;
          r.alert = (conf >= alert_limit);
        end else begin
          conf = '0;
        end
        trk_conf[k]      = conf;
        trk_last_time[k] = now;
        trk_last_iv[k]   = cur;
        r.status         = ST_KNOWN;
        r.interval_ms    = MS_W'(cur / DIVISOR);
        r.conf           = conf;
        return r;
      end
    end
    if (trk_used < TABLE_ENTRIES) begin
      trk_addr[trk_used]      = addr;
      trk_last_time[trk_used] = now;
      trk_last_iv[trk_used]   = '0;
      trk_conf[trk_used]      = '0;
      trk_used++;
      r.status = ST_NEW;
    end else begin
      r.status = ST_FULL;   // table untouched, other fields stay zero
    end
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // ---------------------------------------------------------------------------
  // Packet sender. tvalid stays high from one word to the next when no gap is
  // drawn, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_packet(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(track_packet(addr, now));
  endtask

  // stop sending and wait until every result is back; block is idle after
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // one register write; cfg_valid is left high so writes can go back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_JITTER: jitter_us   = word;
      CFG_LIMIT:  alert_limit = word[CONF_W-1:0];
      default: ;  // unused index, dropped
    endcase
  endtask

  // drain, write both registers, release the config channel.
  // Limit goes in the low byte; the upper bits of the word are junk.
  task automatic configure(input logic [TIME_W-1:0] jit, input logic [CONF_W-1:0] lim);
    logic [TIME_W-1:0] word;
    word = rand_time();
    word[CONF_W-1:0] = lim;
    drain_results();
    write_reg(CFG_JITTER, jit);
    write_reg(CFG_LIMIT, word);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_idling();
    tx_idle_en = $urandom_range(0, 1);
    rx_idle_en = $urandom_range(0, 1);
  endtask

  // new periods for the pool; a period always exceeds the jitter spread
  task automatic set_periods(input int spread);
    for (int i = 0; i < POOL_N; i++)
      src_period[i] = TIME_W'(spread) + 1 + TIME_W'($urandom_range(0, 4_000_000));
  endtask

  // Mostly on-period packets from the pool with +/- spread jitter; the rest
  // breaks runs (random gap, repeated timestamp) or comes from stray sources.
  task automatic run_beacons(input int n, input int spread);
    int                i;
    int                r;
    logic [TIME_W-1:0] t;
    repeat (n) begin
      i = $urandom_range(0, POOL_N - 1);
      r = $urandom_range(0, 99);
      if (r < 75)
        t = src_time[i] + src_period[i] + TIME_W'($urandom_range(0, 2 * spread))
            - TIME_W'(spread);
      else if (r < 85)
        t = src_time[i] + rand_time();
      else
        t = src_time[i];
      if (r < 90) begin
        send_packet(src_addr[i], t);
        src_time[i] = t;
      end else begin
        send_packet($urandom(), rand_time());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers (100000 us, limit 5): new sources, equal timestamps, the
  // no-previous-interval case, the threshold boundary, wrap and the alert.
  task automatic test_directed();
    send_packet('0, '0);                     // new, lowest address and time
    send_packet('1, TIME_MAX);               // new, highest address and time
    send_packet('0, '0);                     // hit, zero interval
    send_packet('0, TIME_W'(1_000_000));     // stored interval zero -> cleared
    send_packet('0, TIME_W'(2_000_000));     // diff 0 -> conf 1
    send_packet('0, TIME_W'(3_000_050));     // diff 50 -> conf 2
    send_packet('0, TIME_W'(4_100_049));     // diff 99_949 -> conf 3
    send_packet('0, TIME_W'(5_300_048));     // diff exactly 100_000 -> cleared
    // interval straddles the 2^48 wrap, then a steady run up past the limit
    for (int k = 0; k < 7; k++)
      send_packet('1, TIME_W'(999_999 + k * 1_000_000));
    send_packet('1, TIME_W'(6_999_999));     // repeated stamp ends the run
  endtask

  // limit 0 (alert on every increment), 1 and 255; unused indexes ignored
  task automatic test_limit_extremes();
    for (int i = 0; i < POOL_N; i++) begin
      src_addr[i] = $urandom();
      src_time[i] = rand_time();
    end
    src_time[0] = TIME_MAX - TIME_W'($urandom_range(0, 10_000_000));  // wraps soon
    set_periods(30_000);
    drain_results();
    write_reg(CFG_SPARE_LO, rand_time());
    write_reg(CFG_LIMIT, TIME_W'(0));
    write_reg(CFG_SPARE_HI, rand_time());
    cfg_valid <= 1'b0;
    run_beacons(60, 30_000);
    configure(JITTER_RST, CONF_W'(1));
    run_beacons(60, 30_000);
    configure(JITTER_RST, CONF_MAX);
    run_beacons(40, 30_000);
  endtask

  // widest threshold: every nonzero interval counts, confidence pins at 255
  task automatic test_saturation();
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] iv;
    configure(TIME_MAX, CONF_MAX);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    t = rand_time();
    repeat (264) begin
      iv = $urandom_range(0, 1) ? rand_time() : TIME_W'($urandom_range(1, 2_000_000));
      if (iv == '0) iv = 1;
      t = t + iv;
      send_packet(32'hC0A8_0101, t);
    end
  endtask

  // threshold 0 never counts; threshold 1 counts only exact repeats; then the widest threshold
  task automatic test_thresholds();
    configure('0, CONF_W'(3));
    pick_idling();
    set_periods(0);
    run_beacons(100, 0);
    configure(TIME_W'(1), CONF_W'(3));
    pick_idling();
    set_periods(1);
    run_beacons(120, 1);
    configure(TIME_MAX, CONF_W'(4));
    pick_idling();
    set_periods(1_000_000);
    run_beacons(80, 1_000_000);
  endtask

  task automatic test_random_mix();
    logic [TIME_W-1:0] jit;
    int                spread;
    repeat (4) begin
      case ($urandom_range(0, 2))
        0: begin
          jit    = JITTER_RST;
          spread = 40_000;
        end
        1: begin
          jit    = TIME_W'($urandom_range(2, 2_000_000));
          spread = int'(jit / 2) + 1;   // jitter lands on both sides of the threshold
        end
        default: begin
          jit    = rand_time();
          spread = 1_000_000;
        end
      endcase
      configure(jit, CONF_W'($urandom_range(1, 8)));
      pick_idling();
      set_periods(spread);
      run_beacons(180, spread);
    end
  endtask

  // fill the table with fresh sources, then keep the pool running while
  // strays get turned away
  task automatic test_table_full();
    configure(JITTER_RST, LIMIT_RST);
    pick_idling();
    set_periods(40_000);
    while (trk_used < TABLE_ENTRIES) send_packet($urandom(), rand_time());
    repeat (10) send_packet($urandom(), rand_time());
    run_beacons(200, 40_000);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls on tready, each accepted word checked against
  // the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  initial begin : result_check
    beacon_result_t want;
    int             stall;
    wait (rst_n);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: tdata %h tuser %h", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_tuser[STAT_W-1:0]));
        check_field("alert", 64'(want.alert), 64'(out_tuser[STAT_W]));
        check_field("interval_ms", 64'(want.interval_ms), 64'(out_tdata[MS_W-1:0]));
        check_field("confidence", 64'(want.conf), 64'(out_tdata[MS_W +: CONF_W]));
      end
    end
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : regression
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_saturation();
    test_thresholds();
    test_random_mix();
    test_table_full();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray word
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pbt_pkg.sv
rtl/pbt_cell.sv
rtl/pbt_div1000.sv
rtl/periodic_source_beacon_tracker.sv
verif/tb_top.sv
